@@ sv/ptts_pkg.sv @@
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and codes for the periodic task and timer scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

  typedef enum logic [3:0] {
    CMD_TICK        = 4'd0,
    CMD_REG_TASK    = 4'd1,
    CMD_START_TASK  = 4'd2,
    CMD_STOP_TASK   = 4'd3,
    CMD_SET_PERIOD  = 4'd4,
    CMD_REG_TIMER   = 4'd5,
    CMD_RELOAD      = 4'd6,
    CMD_START_TIMER = 4'd7,
    CMD_STOP_TIMER  = 4'd8,
    CMD_READ_TIMER  = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_DUE     = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_TICK_LEN  = 2'd0,
    CFG_TASK_CAP  = 2'd1,
    CFG_TIMER_CAP = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_EXEC,
    S_TASKS,
    S_TIMERS,
    S_DONE
  } state_e;

  localparam int unsigned TimeW = 32;
  localparam int unsigned DivSteps = 32;

  typedef struct packed {
    logic [TimeW-1:0] period;
    logic [TimeW-1:0] elapsed;
    logic             enabled;
  } task_ent_t;

  typedef struct packed {
    logic [TimeW-1:0] timeout;
    logic [TimeW-1:0] countdown;
    logic             running;
    logic             notify;
  } tmr_ent_t;

endpackage

@@ sv/periodic_task_and_timer_scheduler.sv @@
// ----------------------------------------------------------------------------
// periodic_task_and_timer_scheduler
// Task and timer tables in two single-port-read synchronous memories.
//
// A request is taken when start is high and busy is low; busy stays high
// until the request is finished. Results come out one per cycle on the
// result ports, marked by result_valid_o, and must be taken as they appear.
// Start/stop/read requests pass through a read and an execute state;
// register, set-period and reload first run the tick-multiple check, a
// 1-bit-per-cycle remainder unit over the 32-bit time value. On a tick
// each table is walked one entry per cycle through its memory (an entry
// is read, then updated and written back in the cycle after), then the done
// marker is issued. Results trail the cycle that produced them by one register.
// ----------------------------------------------------------------------------
module periodic_task_and_timer_scheduler #(
  parameter int TASK_SLOTS  = 8,
  parameter int TIMER_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command_i,
  input  logic [7:0]  slot_id_i,
  input  logic [31:0] time_value_i,
  input  logic        has_callback_i,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // results
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic        ok_o,
  output logic [3:0]  item_id_o,
  output logic [31:0] count_value_o,
  output logic        last_o
);

  localparam int TCW = $clog2(TASK_SLOTS + 1);
  localparam int TIW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int MCW = $clog2(TIMER_SLOTS + 1);
  localparam int MIW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  ptts_pkg::state_e    state_q, state_d;
  logic [3:0]          cmd_q, cmd_d;
  logic [7:0]          id_q, id_d;
  logic [31:0]         tv_q, tv_d;
  logic                cb_q, cb_d;

  logic [31:0]         tick_len_q;
  logic [3:0]          task_cap_q;
  logic [3:0]          timer_cap_q;

  logic [TCW-1:0]      task_total_q, task_total_d;
  logic [MCW-1:0]      timer_total_q, timer_total_d;

  logic [31:0]         div_rem_q, div_rem_d;
  logic [31:0]         div_dvd_q, div_dvd_d;
  logic [4:0]          div_cnt_q, div_cnt_d;

  logic [TCW-1:0]      tcnt_q, tcnt_d;
  logic [MCW-1:0]      mcnt_q, mcnt_d;
  logic                tpend_q, tpend_d;
  logic [TIW-1:0]      tpend_idx_q, tpend_idx_d;
  logic                mpend_q, mpend_d;
  logic [MIW-1:0]      mpend_idx_q, mpend_idx_d;

  logic                res_valid_q, res_valid_d;
  ptts_pkg::kind_e     res_kind_q, res_kind_d;
  logic                res_ok_q, res_ok_d;
  logic [3:0]          res_id_q, res_id_d;
  logic [31:0]         res_cnt_q, res_cnt_d;
  logic                res_last_q, res_last_d;

  // memories
  ptts_pkg::task_ent_t task_mem [TASK_SLOTS];
  ptts_pkg::tmr_ent_t  tmr_mem  [TIMER_SLOTS];
  ptts_pkg::task_ent_t task_rdata_q, task_wdata;
  ptts_pkg::tmr_ent_t  tmr_rdata_q, tmr_wdata;
  logic                task_re, task_we, tmr_re, tmr_we;
  logic [TIW-1:0]      task_raddr, task_waddr;
  logic [MIW-1:0]      tmr_raddr, tmr_waddr;

  // --------------------------------------------------------------------------
  // Decode helpers
  // --------------------------------------------------------------------------
  logic           task_ok, timer_ok, task_room, timer_room, mult, needs_div;
  logic [TIW-1:0] tidx;
  logic [MIW-1:0] midx;
  logic [32:0]    div_sh;
  logic [32:0]    e_sum;
  logic [31:0]    e_sat;
  logic           due;
  logic [31:0]    cd_next;

  assign task_ok   = (id_q != 8'd0) && (32'(id_q) <= 32'(task_total_q));
  assign timer_ok  = (id_q != 8'd0) && (32'(id_q) <= 32'(timer_total_q));
  assign tidx      = task_ok ? TIW'(id_q - 8'd1) : '0;
  assign midx      = timer_ok ? MIW'(id_q - 8'd1) : '0;
  assign task_room = (32'(task_total_q) < 32'(task_cap_q)) &&
                     (32'(task_total_q) < 32'(TASK_SLOTS));
  assign timer_room = (32'(timer_total_q) < 32'(timer_cap_q)) &&
                      (32'(timer_total_q) < 32'(TIMER_SLOTS));
  // zero tick length: every value counts as a multiple
  assign mult      = (tick_len_q == 32'd0) || (div_rem_q == 32'd0);
  assign needs_div = (command_i == ptts_pkg::CMD_REG_TASK) ||
                     (command_i == ptts_pkg::CMD_SET_PERIOD) ||
                     (command_i == ptts_pkg::CMD_REG_TIMER) ||
                     (command_i == ptts_pkg::CMD_RELOAD);

  // restoring remainder step
  assign div_sh  = {div_rem_q, div_dvd_q[31]};

  // tick update of one entry
  assign e_sum   = {1'b0, task_rdata_q.elapsed} + {1'b0, tick_len_q};
  assign e_sat   = e_sum[32] ? 32'hFFFF_FFFF : e_sum[31:0];
  assign due     = task_rdata_q.enabled && (e_sat >= task_rdata_q.period);
  assign cd_next = tmr_rdata_q.countdown - tick_len_q;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptts_pkg::S_IDLE: begin
        if (start) begin
          if (command_i == ptts_pkg::CMD_TICK) state_d = ptts_pkg::S_TASKS;
          else if (needs_div)                  state_d = ptts_pkg::S_DIV;
          else                                 state_d = ptts_pkg::S_READ;
        end
      end
      ptts_pkg::S_DIV: begin
        if (div_cnt_q == 5'(ptts_pkg::DivSteps - 1)) state_d = ptts_pkg::S_READ;
      end
      ptts_pkg::S_READ:   state_d = ptts_pkg::S_EXEC;
      ptts_pkg::S_EXEC:   state_d = ptts_pkg::S_IDLE;
      ptts_pkg::S_TASKS: begin
        if (tcnt_q >= task_total_q) state_d = ptts_pkg::S_TIMERS;
      end
      ptts_pkg::S_TIMERS: begin
        if (mcnt_q >= timer_total_q) state_d = ptts_pkg::S_DONE;
      end
      ptts_pkg::S_DONE:   state_d = ptts_pkg::S_IDLE;
      default:            state_d = ptts_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    cmd_d         = cmd_q;
    id_d          = id_q;
    tv_d          = tv_q;
    cb_d          = cb_q;
    task_total_d  = task_total_q;
    timer_total_d = timer_total_q;
    div_rem_d     = div_rem_q;
    div_dvd_d     = div_dvd_q;
    div_cnt_d     = div_cnt_q;
    tcnt_d        = tcnt_q;
    mcnt_d        = mcnt_q;
    tpend_d       = 1'b0;
    tpend_idx_d   = tpend_idx_q;
    mpend_d       = 1'b0;
    mpend_idx_d   = mpend_idx_q;

    res_valid_d   = 1'b0;
    res_kind_d    = ptts_pkg::KIND_STATUS;
    res_ok_d      = 1'b0;
    res_id_d      = 4'd0;
    res_cnt_d     = 32'd0;
    res_last_d    = 1'b0;

    task_re       = 1'b0;
    task_raddr    = tidx;
    task_we       = 1'b0;
    task_waddr    = tidx;
    task_wdata    = task_rdata_q;
    tmr_re        = 1'b0;
    tmr_raddr     = midx;
    tmr_we        = 1'b0;
    tmr_waddr     = midx;
    tmr_wdata     = tmr_rdata_q;

    unique case (state_q)
      ptts_pkg::S_IDLE: begin
        tcnt_d = '0;
        mcnt_d = '0;
        if (start) begin
          cmd_d     = command_i;
          id_d      = slot_id_i;
          tv_d      = time_value_i;
          cb_d      = has_callback_i;
          div_rem_d = 32'd0;
          div_dvd_d = time_value_i;
          div_cnt_d = 5'd0;
        end
      end

      ptts_pkg::S_DIV: begin
        if (div_sh >= {1'b0, tick_len_q}) div_rem_d = 32'(div_sh - {1'b0, tick_len_q});
        else                              div_rem_d = div_sh[31:0];
        div_dvd_d = {div_dvd_q[30:0], 1'b0};
        div_cnt_d = div_cnt_q + 5'd1;
      end

      ptts_pkg::S_READ: begin
        task_re = 1'b1;
        tmr_re  = 1'b1;
      end

      ptts_pkg::S_EXEC: begin
        res_valid_d = 1'b1;
        res_last_d  = 1'b1;
        unique case (cmd_q)
          ptts_pkg::CMD_REG_TASK: begin
            if (task_room && mult) begin
              task_we      = 1'b1;
              task_waddr   = task_total_q[TIW-1:0];
              task_wdata   = '{period: tv_q, elapsed: 32'd0, enabled: 1'b1};
              task_total_d = task_total_q + 1'b1;
              res_ok_d     = 1'b1;
              res_id_d     = 4'(32'(task_total_q) + 32'd1);
            end
          end
          ptts_pkg::CMD_START_TASK, ptts_pkg::CMD_STOP_TASK: begin
            if (task_ok) begin
              task_we            = 1'b1;
              task_wdata.enabled = (cmd_q == ptts_pkg::CMD_START_TASK);
              res_ok_d           = 1'b1;
            end
          end
          ptts_pkg::CMD_SET_PERIOD: begin
            if (task_ok && mult) begin
              task_we           = 1'b1;
              task_wdata.period = tv_q;
              res_ok_d          = 1'b1;
            end
          end
          ptts_pkg::CMD_REG_TIMER: begin
            if (timer_room && mult) begin
              tmr_we        = 1'b1;
              tmr_waddr     = timer_total_q[MIW-1:0];
              tmr_wdata     = '{timeout: tv_q, countdown: tv_q, running: 1'b0,
                                notify: cb_q};
              timer_total_d = timer_total_q + 1'b1;
              res_ok_d      = 1'b1;
              res_id_d      = 4'(32'(timer_total_q) + 32'd1);
            end
          end
          ptts_pkg::CMD_RELOAD: begin
            if (timer_ok && mult) begin
              tmr_we              = 1'b1;
              tmr_wdata.timeout   = tv_q;
              tmr_wdata.countdown = tv_q;
              tmr_wdata.running   = 1'b1;
              res_ok_d            = 1'b1;
            end
          end
          ptts_pkg::CMD_START_TIMER: begin
            if (timer_ok) begin
              tmr_we              = 1'b1;
              tmr_wdata.countdown = tmr_rdata_q.timeout;
              tmr_wdata.running   = 1'b1;
              res_ok_d            = 1'b1;
            end
          end
          ptts_pkg::CMD_STOP_TIMER: begin
            if (timer_ok) begin
              tmr_we            = 1'b1;
              tmr_wdata.running = 1'b0;
              res_ok_d          = 1'b1;
            end
          end
          ptts_pkg::CMD_READ_TIMER: begin
            if (timer_ok) begin
              res_cnt_d = tmr_rdata_q.countdown;
              res_ok_d  = 1'b1;
            end
          end
          default: ;  // tick never gets here; unknown codes give ok=0
        endcase
      end

      ptts_pkg::S_TASKS: begin
        // read entry n while entry n-1 is updated and written back
        if (tcnt_q < task_total_q) begin
          task_re     = 1'b1;
          task_raddr  = tcnt_q[TIW-1:0];
          tpend_d     = 1'b1;
          tpend_idx_d = tcnt_q[TIW-1:0];
          tcnt_d      = tcnt_q + 1'b1;
        end
        if (tpend_q) begin
          task_we            = 1'b1;
          task_waddr         = tpend_idx_q;
          task_wdata.elapsed = due ? 32'd0 : e_sat;
          if (due) begin
            res_valid_d = 1'b1;
            res_kind_d  = ptts_pkg::KIND_DUE;
            res_ok_d    = 1'b1;
            res_id_d    = 4'(32'(tpend_idx_q) + 32'd1);
          end
        end
      end

      ptts_pkg::S_TIMERS: begin
        if (mcnt_q < timer_total_q) begin
          tmr_re      = 1'b1;
          tmr_raddr   = mcnt_q[MIW-1:0];
          mpend_d     = 1'b1;
          mpend_idx_d = mcnt_q[MIW-1:0];
          mcnt_d      = mcnt_q + 1'b1;
        end
        if (mpend_q && tmr_rdata_q.running) begin
          tmr_we              = 1'b1;
          tmr_waddr           = mpend_idx_q;
          tmr_wdata.countdown = cd_next;
          // expiry without notify keeps running and wraps
          if ((cd_next == 32'd0) && tmr_rdata_q.notify) begin
            tmr_wdata.running = 1'b0;
            res_valid_d       = 1'b1;
            res_kind_d        = ptts_pkg::KIND_EXPIRED;
            res_ok_d          = 1'b1;
            res_id_d          = 4'(32'(mpend_idx_q) + 32'd1);
          end
        end
      end

      ptts_pkg::S_DONE: begin
        res_valid_d = 1'b1;
        res_kind_d  = ptts_pkg::KIND_DONE;
        res_ok_d    = 1'b1;
        res_last_d  = 1'b1;
      end

      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ptts_pkg::S_IDLE;
      task_total_q  <= '0;
      timer_total_q <= '0;
      div_cnt_q     <= 5'd0;
      tcnt_q        <= '0;
      mcnt_q        <= '0;
      tpend_q       <= 1'b0;
      mpend_q       <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      task_total_q  <= task_total_d;
      timer_total_q <= timer_total_d;
      div_cnt_q     <= div_cnt_d;
      tcnt_q        <= tcnt_d;
      mcnt_q        <= mcnt_d;
      tpend_q       <= tpend_d;
      mpend_q       <= mpend_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_len_q  <= 32'd1;
      task_cap_q  <= 4'd8;
      timer_cap_q <= 4'd8;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ptts_pkg::CFG_TICK_LEN:  tick_len_q  <= cfg_data_i;
        ptts_pkg::CFG_TASK_CAP:  task_cap_q  <= cfg_data_i[3:0];
        ptts_pkg::CFG_TIMER_CAP: timer_cap_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    id_q        <= id_d;
    tv_q        <= tv_d;
    cb_q        <= cb_d;
    div_rem_q   <= div_rem_d;
    div_dvd_q   <= div_dvd_d;
    tpend_idx_q <= tpend_idx_d;
    mpend_idx_q <= mpend_idx_d;
    res_kind_q  <= res_kind_d;
    res_ok_q    <= res_ok_d;
    res_id_q    <= res_id_d;
    res_cnt_q   <= res_cnt_d;
    res_last_q  <= res_last_d;
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (task_we) task_mem[task_waddr] <= task_wdata;
    if (task_re) task_rdata_q <= task_mem[task_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tmr_we) tmr_mem[tmr_waddr] <= tmr_wdata;
    if (tmr_re) tmr_rdata_q <= tmr_mem[tmr_raddr];
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign busy           = (state_q != ptts_pkg::S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign kind_o         = res_kind_q;
  assign ok_o           = res_ok_q;
  assign item_id_o      = res_id_q;
  assign count_value_o  = res_cnt_q;
  assign last_o         = res_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(task_total_q) <= 32'(TASK_SLOTS)) && (32'(timer_total_q) <= 32'(TIMER_SLOTS)))
    else $error("table total above slot count");

  a_pend_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tpend_q |-> (32'(tpend_idx_q) < 32'(task_total_q)))
    else $error("task walk beyond registered entries");

  a_done_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o == ptts_pkg::KIND_DONE)) |->
      ($past(state_q) == ptts_pkg::S_DONE))
    else $error("done marker outside tick end");

  a_status_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o == ptts_pkg::KIND_STATUS)) |->
      ($past(state_q) == ptts_pkg::S_EXEC) && last_o)
    else $error("status result without a command");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

endmodule
